### src/mris_pkg.sv
`default_nettype none

package mris_pkg;

  // Request kinds carried on in_tuser
  localparam logic [1:0] OP_STEP        = 2'd0;
  localparam logic [1:0] OP_LOAD_INSTR  = 2'd1;
  localparam logic [1:0] OP_WRITE_DATA  = 2'd2;
  localparam logic [1:0] OP_WRITE_REG   = 2'd3;

  // Instruction opcodes, bits [15:12]
  localparam logic [3:0] OPC_RTYPE = 4'd0;
  localparam logic [3:0] OPC_J     = 4'd2;
  localparam logic [3:0] OPC_LW    = 4'd4;
  localparam logic [3:0] OPC_SW    = 4'd5;

  localparam logic [2:0] FUNCT_ADD = 3'd0;

  // Result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_END        = 3'd1;
  localparam logic [2:0] ST_BAD_FUNCT  = 3'd2;
  localparam logic [2:0] ST_BAD_OPCODE = 3'd3;
  localparam logic [2:0] ST_BAD_ADDR   = 3'd4;

  localparam int NUM_REGS   = 8;
  localparam int REG_AW     = 3;
  localparam int PC_W       = 12;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int USED_W     = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [2:0]      status;
    logic [PC_W-1:0] pc_after;
    logic            reg_written;
    logic [2:0]      reg_number;
    logic [31:0]     reg_value;
    logic            mem_written;
    logic [7:0]      mem_address;
    logic [31:0]     mem_value;
  } res_t;

endpackage

`default_nettype wire

### src/mris_ram.sv
`default_nettype none

module mris_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/mris_regfile.sv
`default_nettype none

module mris_regfile
  import mris_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [REG_AW-1:0]     waddr,
  input  wire logic [DATA_WIDTH-1:0] wdata,
  input  wire logic [REG_AW-1:0]     raddr0,
  input  wire logic [REG_AW-1:0]     raddr1,
  output logic      [DATA_WIDTH-1:0] rdata0,
  output logic      [DATA_WIDTH-1:0] rdata1
);

  logic [DATA_WIDTH-1:0] mem [NUM_REGS];

  // Write-first: a read on the same edge as a write to that register sees the new value
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= (we && waddr == raddr0) ? wdata : mem[raddr0];
    rdata1 <= (we && waddr == raddr1) ? wdata : mem[raddr1];
  end

endmodule

`default_nettype wire

### src/mris_res_fifo.sv
`default_nettype none

module mris_res_fifo
  import mris_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire res_t push_data,
  input  wire logic pop,
  output logic      valid,
  output res_t      head
);

  res_t               slot_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [USED_W-1:0]  count_r;
  logic [USED_W-1:0]  count_nxt;
  logic               do_pop;

  assign valid  = (count_r != '0);
  assign head   = slot_r[rd_ptr_r];
  assign do_pop = pop && valid;

  always_comb begin
    count_nxt = count_r + USED_W'(push) - USED_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

### src/mini_risc_instruction_step_unit.sv
`default_nettype none

// Request engine for a small processor with 16-bit instructions (ADD, LW, SW, J). A request
// loads an instruction word, writes a data word or a register, or executes one instruction
// at the program counter; every request returns exactly one result. No new request is taken
// while the last one is in decode: the instruction fetch and the register-file read that follows
// it are two back-to-back synchronous memory reads. Results pass the decode and execute stages
// (and a memory stage for LW, which adds a data-memory read) and wait in a four-entry result
// queue, so requests keep flowing while the consumer stalls, until four results are outstanding.
// After reset the register file and all DMEM_DEPTH data-memory words are cleared, during which
// in_tready stays low; program_length may be written at any time the block is idle.

module mini_risc_instruction_step_unit
  import mris_pkg::*;
#(
  parameter int IMEM_DEPTH = 256,
  parameter int DMEM_DEPTH = 256,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // program_length
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // target_index[7:0], data_word[39:8], instruction_word[55:40]
  input  wire logic [55:0] in_tdata,
  // opcode[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // pc_after[11:0], reg_number[14:12], reg_value[46:15], mem_address[54:47],
  // mem_value[86:55], zero[87]
  output logic      [87:0] out_tdata,
  // status[2:0], reg_written[3], mem_written[4]
  output logic      [4:0]  out_tuser
);

  localparam int IAW = $clog2(IMEM_DEPTH);
  localparam int DAW = $clog2(DMEM_DEPTH);
  localparam int DW  = DATA_WIDTH;
  localparam int SAW = DATA_WIDTH + 14;

  function automatic logic [31:0] to32(input logic [DW-1:0] v);
    logic [DW+31:0] t;
    t = {32'b0, v};
    return t[31:0];
  endfunction

  // ---------------- input side ----------------
  logic [1:0]      in_op;
  logic [7:0]      in_idx;
  logic [31:0]     in_dword;
  logic [15:0]     in_iword;
  logic [DW+31:0]  in_wide;
  logic [DW-1:0]   in_data;
  logic [11:0]     in_idx12;
  logic            in_fire;
  logic            ended;
  logic [12:0]     pc13;

  logic [PC_W-1:0]   pc_r, pc_nxt;
  logic [8:0]        len_r;
  logic [DAW-1:0]    clr_r;
  logic              clr_busy_r;
  logic [USED_W-1:0] used_r, used_nxt;

  assign in_op    = in_tuser;
  assign in_idx   = in_tdata[7:0];
  assign in_dword = in_tdata[39:8];
  assign in_iword = in_tdata[55:40];
  assign in_wide  = {{DW{in_dword[31]}}, in_dword};
  assign in_data  = in_wide[DW-1:0];
  assign in_idx12 = {4'b0, in_idx};

  logic d_v_r;

  assign cfg_ready = 1'b1;
  assign in_tready = !clr_busy_r && !d_v_r && (used_r != USED_W'(FIFO_DEPTH));
  assign in_fire   = in_tvalid && in_tready;

  assign pc13  = {1'b0, pc_r};
  assign ended = (pc13 >= {4'b0, len_r}) || (pc13 >= 13'(IMEM_DEPTH));

  // ---------------- instruction memory ----------------
  logic            im_we;
  logic [15:0]     imem_q;

  assign im_we = in_fire && in_op == OP_LOAD_INSTR && ({5'b0, in_idx} < 13'(IMEM_DEPTH));

  mris_ram #(
    .WIDTH (16),
    .DEPTH (IMEM_DEPTH)
  ) u_imem (
    .clk   (clk),
    .we    (im_we),
    .waddr (in_idx12[IAW-1:0]),
    .wdata (in_iword),
    .re    (in_fire && in_op == OP_STEP),
    .raddr (pc_r[IAW-1:0]),
    .rdata (imem_q)
  );

  // ---------------- decode stage ----------------
  logic [1:0]    d_op_r;
  logic [7:0]    d_idx_r;
  logic [DW-1:0] d_data_r;
  logic          d_end_r;
  logic [3:0]    d_opc;
  logic          d_step_go;
  logic [REG_AW-1:0] rf_ra1;

  assign d_opc     = imem_q[15:12];
  assign d_step_go = d_v_r && d_op_r == OP_STEP && !d_end_r;
  assign rf_ra1    = (d_opc == OPC_RTYPE) ? imem_q[5:3] : imem_q[11:9];

  always_comb begin
    pc_nxt = pc_r;
    if (d_step_go) begin
      pc_nxt = (d_opc == OPC_J) ? imem_q[11:0] : pc_r + 12'd1;
    end
  end

  // ---------------- execute stage ----------------
  logic              x_v_r;
  logic [1:0]        x_op_r;
  logic [7:0]        x_idx_r;
  logic [DW-1:0]     x_data_r;
  logic              x_end_r;
  logic [3:0]        x_opc_r;
  logic [REG_AW-1:0] x_a_r;
  logic [2:0]        x_funct_r;
  logic [5:0]        x_imm_r;

  logic [DW-1:0]     rs, rt, sum_rr;
  logic [SAW-1:0]    addr_sum;
  logic              addr_ok;
  logic              x_didx_ok;
  logic [11:0]       x_idx12;

  logic              rf_we_x;
  logic [REG_AW-1:0] rf_wa_x;
  logic [DW-1:0]     rf_wd_x;
  logic              dm_we_x;
  logic [DAW-1:0]    dm_wa_x;
  logic [DW-1:0]     dm_wd_x;
  logic              lw_go;
  res_t              res_x;

  assign sum_rr    = rs + rt;
  assign addr_sum  = SAW'(rs) + SAW'(x_imm_r);
  assign addr_ok   = !rs[DW-1] && (addr_sum < SAW'(DMEM_DEPTH));
  assign x_didx_ok = {5'b0, x_idx_r} < 13'(DMEM_DEPTH);
  assign x_idx12   = {4'b0, x_idx_r};

  always_comb begin
    rf_we_x = 1'b0;
    rf_wa_x = x_a_r;
    rf_wd_x = sum_rr;
    dm_we_x = 1'b0;
    dm_wa_x = addr_sum[DAW-1:0];
    dm_wd_x = rt;
    lw_go   = 1'b0;
    res_x   = '0;
    res_x.status = ST_OK;
    unique case (x_op_r)
      OP_STEP: begin
        if (x_end_r) begin
          res_x.status = ST_END;
        end else begin
          unique case (x_opc_r)
            OPC_RTYPE: begin
              if (x_funct_r == FUNCT_ADD) begin
                rf_we_x           = 1'b1;
                res_x.reg_written = 1'b1;
                res_x.reg_number  = x_a_r;
                res_x.reg_value   = to32(sum_rr);
              end else begin
                res_x.status = ST_BAD_FUNCT;
              end
            end
            OPC_LW: begin
              if (addr_ok) begin
                lw_go = 1'b1;
              end else begin
                res_x.status = ST_BAD_ADDR;
              end
            end
            OPC_SW: begin
              if (addr_ok) begin
                dm_we_x           = 1'b1;
                res_x.mem_written = 1'b1;
                res_x.mem_address = addr_sum[7:0];
                res_x.mem_value   = to32(rt);
              end else begin
                res_x.status = ST_BAD_ADDR;
              end
            end
            OPC_J: begin
              res_x.status = ST_OK;
            end
            default: begin
              res_x.status = ST_BAD_OPCODE;
            end
          endcase
        end
      end
      OP_LOAD_INSTR: begin
        res_x.status = ST_OK;
      end
      OP_WRITE_DATA: begin
        if (x_didx_ok) begin
          dm_we_x = 1'b1;
          dm_wa_x = x_idx12[DAW-1:0];
          dm_wd_x = x_data_r;
        end else begin
          res_x.status = ST_BAD_ADDR;
        end
      end
      OP_WRITE_REG: begin
        if (x_idx_r < 8'(NUM_REGS)) begin
          rf_we_x = 1'b1;
          rf_wa_x = x_idx_r[REG_AW-1:0];
          rf_wd_x = x_data_r;
        end
      end
      default: begin
        res_x.status = ST_OK;
      end
    endcase
    // hold every side effect to a live request
    rf_we_x = rf_we_x && x_v_r;
    dm_we_x = dm_we_x && x_v_r;
    lw_go   = lw_go && x_v_r;
    res_x.pc_after = pc_r;
  end

  // ---------------- memory stage (LW only) ----------------
  logic              m_v_r;
  logic [REG_AW-1:0] m_a_r;
  logic [DW-1:0]     dmem_q;
  res_t              res_m;

  always_comb begin
    res_m             = '0;
    res_m.status      = ST_OK;
    res_m.pc_after    = pc_r;
    res_m.reg_written = 1'b1;
    res_m.reg_number  = m_a_r;
    res_m.reg_value   = to32(dmem_q);
  end

  // ---------------- data memory and register file ports ----------------
  logic              clr_rf;
  logic              rf_we;
  logic [REG_AW-1:0] rf_wa;
  logic [DW-1:0]     rf_wd;
  logic              dm_we;
  logic [DAW-1:0]    dm_wa;
  logic [DW-1:0]     dm_wd;

  assign clr_rf = clr_busy_r && (clr_r < DAW'(NUM_REGS));

  always_comb begin
    if (clr_rf) begin
      rf_we = 1'b1;
      rf_wa = clr_r[REG_AW-1:0];
      rf_wd = '0;
    end else if (m_v_r) begin
      rf_we = 1'b1;
      rf_wa = m_a_r;
      rf_wd = dmem_q;
    end else begin
      rf_we = rf_we_x;
      rf_wa = rf_wa_x;
      rf_wd = rf_wd_x;
    end
    if (clr_busy_r) begin
      dm_we = 1'b1;
      dm_wa = clr_r;
      dm_wd = '0;
    end else begin
      dm_we = dm_we_x;
      dm_wa = dm_wa_x;
      dm_wd = dm_wd_x;
    end
  end

  mris_regfile #(
    .DATA_WIDTH (DW)
  ) u_regfile (
    .clk    (clk),
    .we     (rf_we),
    .waddr  (rf_wa),
    .wdata  (rf_wd),
    .raddr0 (imem_q[8:6]),
    .raddr1 (rf_ra1),
    .rdata0 (rs),
    .rdata1 (rt)
  );

  mris_ram #(
    .WIDTH (DW),
    .DEPTH (DMEM_DEPTH)
  ) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_wa),
    .wdata (dm_wd),
    .re    (lw_go),
    .raddr (addr_sum[DAW-1:0]),
    .rdata (dmem_q)
  );

  // ---------------- result queue ----------------
  logic push_x, push_m, out_pop;
  res_t head;

  assign push_x  = x_v_r && !lw_go;
  assign push_m  = m_v_r;
  assign out_pop = out_tvalid && out_tready;

  mris_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push_x || push_m),
    .push_data (push_m ? res_m : res_x),
    .pop       (out_tready),
    .valid     (out_tvalid),
    .head      (head)
  );

  assign out_tdata = {1'b0, head.mem_value, head.mem_address, head.reg_value,
                      head.reg_number, head.pc_after};
  assign out_tuser = {head.mem_written, head.reg_written, head.status};

  // queue slots promised to accepted requests
  always_comb begin
    used_nxt = used_r + USED_W'(in_fire) - USED_W'(out_pop);
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      d_op_r   <= in_op;
      d_idx_r  <= in_idx;
      d_data_r <= in_data;
      d_end_r  <= ended;
    end
    x_op_r    <= d_op_r;
    x_idx_r   <= d_idx_r;
    x_data_r  <= d_data_r;
    x_end_r   <= d_end_r;
    x_opc_r   <= d_opc;
    x_a_r     <= imem_q[11:9];
    x_funct_r <= imem_q[2:0];
    x_imm_r   <= imem_q[5:0];
    m_a_r     <= x_a_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r      <= 1'b0;
      x_v_r      <= 1'b0;
      m_v_r      <= 1'b0;
      pc_r       <= '0;
      len_r      <= '0;
      clr_r      <= '0;
      clr_busy_r <= 1'b1;
      used_r     <= '0;
    end else begin
      d_v_r  <= in_fire;
      x_v_r  <= d_v_r;
      m_v_r  <= lw_go;
      pc_r   <= pc_nxt;
      used_r <= used_nxt;
      if (cfg_valid) begin
        len_r <= cfg_data;
      end
      if (clr_busy_r) begin
        clr_r <= clr_r + 1'b1;
        if (clr_r == DAW'(DMEM_DEPTH - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  // ---------------- assertions ----------------
  a_one_push: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_x && push_m))
    else $error("execute and memory stages pushed a result in the same cycle");

  a_rf_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(m_v_r && rf_we_x))
    else $error("two register-file writes collided");

  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (used_r != '0))
    else $error("result queued without an outstanding request");

  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_fire)
    else $error("requests accepted on consecutive cycles");

endmodule

`default_nettype wire
